// ===== hdl/lrsfg_pkg.sv =====
// Shared types and constants for the LED ring segment frame generator.
// No dependencies.
`timescale 1ns / 1ps

package lrsfg_pkg;

   localparam int START_BYTES = 4;
   localparam int END_BYTES   = 6;

   localparam logic [7:0] HEADER_BASE    = 8'hE0;
   localparam logic [7:0] END_BYTE       = 8'hFF;
   localparam logic [7:0] COLOR_ON_BYTE  = 8'd255;
   localparam logic [7:0] COLOR_OFF_BYTE = 8'h00;
   localparam logic [7:0] START_BYTE     = 8'h00;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BRIGHTNESS = 2'd0,
      CSR_GROUPS     = 2'd1,
      CSR_START      = 2'd2,
      CSR_LENGTH     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_COLOR  = 2'd2,
      KIND_END    = 2'd3
   } byte_kind_type;

   typedef enum logic [3:0] {
      SEQ_LOAD   = 4'b0001,
      SEQ_REDUCE = 4'b0010,
      SEQ_SWEEP  = 4'b0100,
      SEQ_READY  = 4'b1000
   } seq_state_type;

endpackage

// ===== hdl/led_ring_segment_frame_generator.sv =====
// Top level of the LED ring segment frame generator: lit map sequencer,
// byte position counter and output pipeline. Uses lrsfg_pkg and lrsfg_ram.
//
// Channel   Dir  Ports                                   Payload
// req       in   req_tvalid/req_tready/req_tdata          bit 0 restart
// rsp       out  rsp_tvalid/rsp_tready/rsp_tdata/tlast    frame byte, last-of-frame
// csr       in   csr_valid/csr_ready/csr_index/csr_data   register write
//
// One byte per cycle sustained while rsp does not stall and no lit map rebuild
// runs. A request is accepted with the lit map read into stage s1, then the byte
// is built into the output register. The lit map RAM (one bit per LED) is rebuilt
// after reset and after every csr transfer, through the load, reduce and sweep
// states, during which req_tready is low. csr_ready is always high.
// A stall on rsp holds the output and backs up through the pipeline to req.
`timescale 1ns / 1ps

module led_ring_segment_frame_generator
   import lrsfg_pkg::*;
#(
   parameter int LED_COUNT  = 72,
   parameter int MAX_GROUPS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] restart
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] frame_byte
   output logic                   rsp_tlast,   // frame_last
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int FrameBytes = START_BYTES + 4 * LED_COUNT + END_BYTES;
   localparam int LedEnd     = START_BYTES + 4 * LED_COUNT;
   localparam int PosW       = $clog2(FrameBytes);
   localparam int LedW       = $clog2(LED_COUNT);
   localparam int CntW       = $clog2(LED_COUNT + 1);
   localparam int SumW       = CntW + 1;
   localparam int GrpW       = $clog2(MAX_GROUPS + 1);

   // ---------------- configuration registers
   logic [4:0] bright_ff, bright_in;
   logic [2:0] groups_ff, groups_in;
   logic [6:0] start_ff,  start_in;
   logic [6:0] length_ff, length_in;
   logic       csr_xfer;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_comb begin
      bright_in = bright_ff;
      groups_in = groups_ff;
      start_in  = start_ff;
      length_in = length_ff;
      if (csr_xfer) begin
         unique case (csr_index_type'(csr_index))
            CSR_BRIGHTNESS: bright_in = csr_data[4:0];
            CSR_GROUPS:     groups_in = csr_data[2:0];
            CSR_START:      start_in  = csr_data;
            CSR_LENGTH:     length_in = csr_data;
            default:        bright_in = bright_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= '0;
         groups_ff <= '0;
         start_ff  <= '0;
         length_ff <= 7'd36;
      end else begin
         bright_ff <= bright_in;
         groups_ff <= groups_in;
         start_ff  <= start_in;
         length_ff <= length_in;
      end
   end

   // ---------------- group tables
   logic [CntW-1:0] offset_tbl [MAX_GROUPS+1][MAX_GROUPS];
   logic [CntW-1:0] maxlen_tbl [MAX_GROUPS+1];

   for (genvar g = 0; g <= MAX_GROUPS; g++) begin : g_tbl
      if (g == 0) begin : g_zero
         assign maxlen_tbl[g] = '0;
         for (genvar j = 0; j < MAX_GROUPS; j++) begin : g_off
            assign offset_tbl[g][j] = '0;
         end
      end else begin : g_some
         localparam int MaxLen = LED_COUNT / g;
         assign maxlen_tbl[g] = CntW'(MaxLen);
         for (genvar j = 0; j < MAX_GROUPS; j++) begin : g_off
            localparam int Offset = (j * LED_COUNT) / g;
            assign offset_tbl[g][j] = (j < g) ? CntW'(Offset) : '0;
         end
      end
   end

   // ---------------- lit map sequencer
   seq_state_type   seq_ff, seq_in;
   logic [6:0]      start_mod_ff, start_mod_in;
   logic [LedW-1:0] led_idx_ff, led_idx_in;
   logic            map_wr;
   logic            start_big;

   assign start_big = ({1'b0, start_mod_ff} >= 8'(LED_COUNT));

   always_comb begin
      seq_in       = seq_ff;
      start_mod_in = start_mod_ff;
      led_idx_in   = led_idx_ff;
      map_wr       = 1'b0;
      unique case (seq_ff)
         SEQ_LOAD: begin
            start_mod_in = start_ff;
            seq_in       = SEQ_REDUCE;
         end
         SEQ_REDUCE: begin
            if (start_big) begin
               start_mod_in = start_mod_ff - 7'(LED_COUNT);
            end else begin
               led_idx_in = '0;
               seq_in     = SEQ_SWEEP;
            end
         end
         SEQ_SWEEP: begin
            map_wr     = 1'b1;
            led_idx_in = led_idx_ff + 1'b1;
            if (led_idx_ff == LedW'(LED_COUNT - 1)) begin
               seq_in = SEQ_READY;
            end
         end
         SEQ_READY: begin
            seq_in = SEQ_READY;
         end
         default: begin
            seq_in = SEQ_LOAD;
         end
      endcase
      if (csr_xfer) begin
         seq_in = SEQ_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_LOAD;
         start_mod_ff <= '0;
         led_idx_ff   <= '0;
      end else begin
         seq_ff       <= seq_in;
         start_mod_ff <= start_mod_in;
         led_idx_ff   <= led_idx_in;
      end
   end

   // lit test of one LED against every group
   logic [GrpW-1:0]       grp_eff;
   logic [CntW-1:0]       len_eff;
   logic [MAX_GROUPS-1:0] hit;
   logic                  lit;

   assign grp_eff = (4'(groups_ff) > 4'(MAX_GROUPS)) ? GrpW'(MAX_GROUPS)
                                                     : GrpW'(groups_ff);

   always_comb begin
      if (length_ff == '0) begin
         len_eff = CntW'(1);
      end else if ({1'b0, length_ff} > 8'(maxlen_tbl[grp_eff])) begin
         len_eff = maxlen_tbl[grp_eff];
      end else begin
         len_eff = CntW'(length_ff);
      end
   end

   for (genvar j = 0; j < MAX_GROUPS; j++) begin : g_lane
      logic [SumW-1:0] base_sum, base, diff, rel;
      assign base_sum = SumW'(start_mod_ff) + SumW'(offset_tbl[grp_eff][j]);
      assign base     = (base_sum >= SumW'(LED_COUNT)) ? base_sum - SumW'(LED_COUNT)
                                                       : base_sum;
      assign diff     = SumW'(led_idx_ff) + SumW'(LED_COUNT) - base;
      assign rel      = (diff >= SumW'(LED_COUNT)) ? diff - SumW'(LED_COUNT) : diff;
      assign hit[j]   = (GrpW'(j) < grp_eff) && (rel < SumW'(len_eff));
   end

   assign lit = (grp_eff == '0) || (|hit);

   // ---------------- output pipeline
   logic            s1_valid_ff, s1_valid_in;
   byte_kind_type   s1_kind_ff;
   logic [4:0]      s1_bright_ff;
   logic            s1_last_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_last_ff;
   logic            out_ready, s1_ready, req_xfer;
   logic [PosW-1:0] pos_ff, pos_in, pos_cur, q;
   byte_kind_type   kind_cur;
   logic            last_cur;
   logic            map_rd_data;
   logic [7:0]      s1_byte;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign req_tready = s1_ready && (seq_ff == SEQ_READY);
   assign req_xfer   = req_tvalid && req_tready;

   assign pos_cur = req_tdata[0] ? '0 : pos_ff;
   assign q       = pos_cur - PosW'(START_BYTES);

   always_comb begin
      last_cur = 1'b0;
      if (pos_cur < PosW'(START_BYTES)) begin
         kind_cur = KIND_START;
      end else if (pos_cur < PosW'(LedEnd)) begin
         kind_cur = (q[1:0] == 2'b00) ? KIND_HEADER : KIND_COLOR;
      end else begin
         kind_cur = KIND_END;
         last_cur = (pos_cur == PosW'(FrameBytes - 1));
      end
   end

   assign pos_in = !req_xfer ? pos_ff
                 : (pos_cur == PosW'(FrameBytes - 1)) ? '0 : pos_cur + 1'b1;

   lrsfg_ram #(
      .WIDTH (1),
      .DEPTH (LED_COUNT)
   ) u_lit_map (
      .clock   (clock),
      .wr_en   (map_wr),
      .wr_addr (led_idx_ff),
      .wr_data (lit),
      .rd_en   (req_xfer),
      .rd_addr (q[LedW+1:2]),
      .rd_data (map_rd_data)
   );

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !out_ready);
   assign rsp_valid_in = (s1_valid_ff && out_ready) || (rsp_valid_ff && !rsp_tready);

   always_comb begin
      unique case (s1_kind_ff)
         KIND_START:  s1_byte = START_BYTE;
         KIND_HEADER: s1_byte = HEADER_BASE | {3'b000, s1_bright_ff};
         KIND_COLOR:  s1_byte = map_rd_data ? COLOR_ON_BYTE : COLOR_OFF_BYTE;
         KIND_END:    s1_byte = END_BYTE;
         default:     s1_byte = START_BYTE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_kind_ff   <= kind_cur;
         s1_bright_ff <= bright_ff;
         s1_last_ff   <= last_cur;
      end
      if (s1_valid_ff && out_ready) begin
         rsp_byte_ff <= s1_byte;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/lrsfg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lrsfg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lrsfg_checker.sv =====
// Port-level checks for the LED ring segment frame generator, bound to the top.
// Uses lrsfg_pkg.
`timescale 1ns / 1ps

module lrsfg_checker
   import lrsfg_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [7:0]             req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [7:0]             rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_data
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == END_BYTE)
      else $error("frame end marked on a non-end byte");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present right after reset");

   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("request taken while lit map rebuilds");

endmodule

bind led_ring_segment_frame_generator lrsfg_checker u_lrsfg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);
